### rtl/ocrp_pkg.sv
// Shared constants and types for the OLED controller command and display-store port.
`timescale 1ns / 1ps
`default_nettype none

package ocrp_pkg;

  // Default geometry of the display store.
  localparam int COLUMNS_DEF   = 128;
  localparam int PAGE_ROWS_DEF = 8;

  // Field widths fixed by the interface.
  localparam int COL_W  = 7;
  localparam int PAGE_W = 3;

  // Commands that carry argument bytes.
  localparam logic [7:0] CMD_ADDR_MODE   = 8'h20;
  localparam logic [7:0] CMD_COL_WINDOW  = 8'h21;
  localparam logic [7:0] CMD_PAGE_WINDOW = 8'h22;
  localparam logic [7:0] CMD_CONTRAST    = 8'h81;
  localparam logic [7:0] CMD_MUX         = 8'hA8;
  localparam logic [7:0] CMD_OFFSET      = 8'hD3;
  localparam logic [7:0] CMD_PINS        = 8'hDA;
  localparam logic [7:0] CMD_CLOCK       = 8'hD5;
  localparam logic [7:0] CMD_PUMP        = 8'h8D;

  // One-byte commands.
  localparam logic [7:0] CMD_SEG_NORMAL  = 8'hA0;
  localparam logic [7:0] CMD_SEG_FLIP    = 8'hA1;
  localparam logic [7:0] CMD_FOLLOW_RAM  = 8'hA4;
  localparam logic [7:0] CMD_ENTIRE_ON   = 8'hA5;
  localparam logic [7:0] CMD_NORMAL      = 8'hA6;
  localparam logic [7:0] CMD_INVERSE     = 8'hA7;
  localparam logic [7:0] CMD_DISPLAY_OFF = 8'hAE;
  localparam logic [7:0] CMD_DISPLAY_ON  = 8'hAF;

  // Command ranges.
  localparam logic [7:0] CMD_START_LINE_LO = 8'h40;
  localparam logic [7:0] CMD_START_LINE_HI = 8'h7F;
  localparam logic [7:0] CMD_COM_SCAN_LO   = 8'hC0;
  localparam logic [7:0] CMD_COM_SCAN_HI   = 8'hCF;
  localparam logic [7:0] CMD_COL_LOW_LO    = 8'h00;
  localparam logic [7:0] CMD_COL_LOW_HI    = 8'h0F;
  localparam logic [7:0] CMD_COL_HIGH_LO   = 8'h10;
  localparam logic [7:0] CMD_COL_HIGH_HI   = 8'h1F;
  localparam logic [7:0] CMD_PAGE_SEL_LO   = 8'hB0;
  localparam logic [7:0] CMD_PAGE_SEL_HI   = 8'hB7;

  // Addressing modes; the fourth code behaves as horizontal.
  localparam logic [1:0] MODE_HORZ = 2'd0;
  localparam logic [1:0] MODE_VERT = 2'd1;
  localparam logic [1:0] MODE_PAGE = 2'd2;

  // Display-store write request.
  typedef struct packed {
    logic              en;
    logic [PAGE_W-1:0] page;
    logic [COL_W-1:0]  column;
    logic [7:0]        data;
  } wr_t;

  // Panel status reported with every result.
  typedef struct packed {
    logic              awaiting_argument;
    logic              scan_reverse;
    logic              segment_flip;
    logic [5:0]        first_line;
    logic [1:0]        address_mode;
    logic [PAGE_W-1:0] page_now;
    logic [COL_W-1:0]  column_now;
    logic              all_pixels_on;
    logic              inverse_video;
    logic [7:0]        contrast_level;
    logic              display_enabled;
  } st_t;

endpackage

`default_nettype wire

### rtl/ocrp_store.sv
// Display store: synchronous memory with a clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module ocrp_store
  import ocrp_pkg::*;
#(
  parameter int COLUMNS   = COLUMNS_DEF,
  parameter int PAGE_ROWS = PAGE_ROWS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire wr_t               wr,
  input  wire logic              rd_en,
  input  wire logic [PAGE_W-1:0] rd_page,
  input  wire logic [COL_W-1:0]  rd_column,
  output logic [7:0]             rd_data,
  output logic                   clearing
);

  localparam int DEPTH  = COLUMNS * PAGE_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [7:0]        mem [DEPTH];
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  // Page-major addressing.
  assign wr_addr = ADDR_W'(int'(wr.page) * COLUMNS + int'(wr.column));
  assign rd_addr = ADDR_W'(int'(rd_page) * COLUMNS + int'(rd_column));

  // Clearing pass: one entry per cycle from address zero upward.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  // Write port, shared by the clearing pass and pixel data.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/ocrp_ctrl.sv
// Command parser, panel settings and write pointer of the display controller.
`timescale 1ns / 1ps
`default_nettype none

module ocrp_ctrl
  import ocrp_pkg::*;
#(
  parameter int COLUMNS   = COLUMNS_DEF,
  parameter int PAGE_ROWS = PAGE_ROWS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic       mode,
  input  wire logic       start_req,
  input  wire logic [7:0] byte_value,
  output wr_t             wr,
  output st_t             st
);

  localparam logic [COL_W-1:0]  COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [PAGE_W-1:0] PG_LAST  = PAGE_W'(PAGE_ROWS - 1);

  // Saturate a column or page value to the last one in the store.
  function automatic logic [COL_W-1:0] sat_col(input logic [COL_W-1:0] v);
    return (v > COL_LAST) ? COL_LAST : v;
  endfunction

  function automatic logic [PAGE_W-1:0] sat_page(input logic [PAGE_W-1:0] v);
    return (v > PG_LAST) ? PG_LAST : v;
  endfunction

  logic              data_phase, data_phase_next;
  logic [7:0]        pending, pending_next;
  logic [1:0]        arg_idx, arg_idx_next;
  logic [COL_W-1:0]  col_start, col_start_next, col_end, col_end_next;
  logic [PAGE_W-1:0] pg_start, pg_start_next, pg_end, pg_end_next;
  logic [COL_W-1:0]  col_ptr, col_ptr_next;
  logic [PAGE_W-1:0] pg_ptr, pg_ptr_next;
  logic [7:0]        contrast, contrast_next;
  logic [5:0]        start_line, start_line_next;
  logic [1:0]        addr_mode, addr_mode_next;
  logic              seg_remap, seg_remap_next;
  logic              com_rev, com_rev_next;
  logic              inverse, inverse_next;
  logic              entire_on, entire_on_next;
  logic              disp_on, disp_on_next;

  logic              col_wrap, pg_wrap;
  logic [COL_W-1:0]  col_step;
  logic [PAGE_W-1:0] pg_step;
  logic              bus_beat;

  assign bus_beat = accept && !mode;

  // Pointer advance with wrap inside the window, or at the end of the store.
  always_comb begin
    col_wrap = (col_ptr == col_end) || (col_ptr >= COL_LAST);
    col_step = col_wrap ? col_start : col_ptr + COL_W'(1);
    pg_wrap  = (pg_ptr == pg_end) || (pg_ptr >= PG_LAST);
    pg_step  = pg_wrap ? pg_start : pg_ptr + PAGE_W'(1);
  end

  // Next state for control, data and argument bytes. Arguments of the mux,
  // offset, pins, clock and pump commands are consumed; no output carries them.
  always_comb begin
    data_phase_next = data_phase;
    pending_next    = pending;
    arg_idx_next    = arg_idx;
    col_start_next  = col_start;
    col_end_next    = col_end;
    pg_start_next   = pg_start;
    pg_end_next     = pg_end;
    col_ptr_next    = col_ptr;
    pg_ptr_next     = pg_ptr;
    contrast_next   = contrast;
    start_line_next = start_line;
    addr_mode_next  = addr_mode;
    seg_remap_next  = seg_remap;
    com_rev_next    = com_rev;
    inverse_next    = inverse;
    entire_on_next  = entire_on;
    disp_on_next    = disp_on;

    if (bus_beat) begin
      if (start_req) begin
        data_phase_next = byte_value[6];
      end else if (data_phase) begin
        case (addr_mode)
          MODE_PAGE: begin
            col_ptr_next = col_step;
          end
          MODE_VERT: begin
            pg_ptr_next = pg_step;
            if (pg_wrap) col_ptr_next = col_step;
          end
          default: begin
            col_ptr_next = col_step;
            if (col_wrap) pg_ptr_next = pg_step;
          end
        endcase
      end else if (arg_idx != 2'd0) begin
        arg_idx_next = arg_idx - 2'd1;
        case (pending)
          CMD_ADDR_MODE: addr_mode_next = byte_value[1:0];
          CMD_COL_WINDOW: begin
            if (arg_idx == 2'd2) begin
              col_start_next = sat_col(byte_value[COL_W-1:0]);
              col_ptr_next   = sat_col(byte_value[COL_W-1:0]);
            end else begin
              col_end_next = sat_col(byte_value[COL_W-1:0]);
            end
          end
          CMD_PAGE_WINDOW: begin
            if (arg_idx == 2'd2) begin
              pg_start_next = sat_page(byte_value[PAGE_W-1:0]);
              pg_ptr_next   = sat_page(byte_value[PAGE_W-1:0]);
            end else begin
              pg_end_next = sat_page(byte_value[PAGE_W-1:0]);
            end
          end
          CMD_CONTRAST: contrast_next = byte_value;
          default: ;
        endcase
      end else begin
        pending_next = byte_value;
        case (byte_value)
          CMD_ADDR_MODE, CMD_CONTRAST, CMD_MUX, CMD_OFFSET,
          CMD_PINS, CMD_CLOCK, CMD_PUMP: arg_idx_next = 2'd1;
          CMD_COL_WINDOW, CMD_PAGE_WINDOW: arg_idx_next = 2'd2;
          CMD_SEG_NORMAL:  seg_remap_next = 1'b0;
          CMD_SEG_FLIP:    seg_remap_next = 1'b1;
          CMD_FOLLOW_RAM:  entire_on_next = 1'b0;
          CMD_ENTIRE_ON:   entire_on_next = 1'b1;
          CMD_NORMAL:      inverse_next   = 1'b0;
          CMD_INVERSE:     inverse_next   = 1'b1;
          CMD_DISPLAY_OFF: disp_on_next   = 1'b0;
          CMD_DISPLAY_ON:  disp_on_next   = 1'b1;
          default: begin
            if (byte_value inside {[CMD_START_LINE_LO:CMD_START_LINE_HI]}) begin
              start_line_next = byte_value[5:0];
            end else if (byte_value inside {[CMD_COM_SCAN_LO:CMD_COM_SCAN_HI]}) begin
              com_rev_next = byte_value[3];
            end else if (addr_mode == MODE_PAGE) begin
              // Page-mode pointer commands; ignored in the other modes.
              if (byte_value inside {[CMD_COL_LOW_LO:CMD_COL_LOW_HI]}) begin
                col_ptr_next = sat_col({col_ptr[6:4], byte_value[3:0]});
              end else if (byte_value inside {[CMD_COL_HIGH_LO:CMD_COL_HIGH_HI]}) begin
                col_ptr_next = sat_col({byte_value[2:0], col_ptr[3:0]});
              end else if (byte_value inside {[CMD_PAGE_SEL_LO:CMD_PAGE_SEL_HI]}) begin
                pg_ptr_next = sat_page(byte_value[PAGE_W-1:0]);
              end
            end
          end
        endcase
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      data_phase <= 1'b0;
      pending    <= '0;
      arg_idx    <= '0;
      col_start  <= '0;
      col_end    <= COL_LAST;
      pg_start   <= '0;
      pg_end     <= PG_LAST;
      col_ptr    <= '0;
      pg_ptr     <= '0;
      contrast   <= 8'h7F;
      start_line <= '0;
      addr_mode  <= MODE_HORZ;
      seg_remap  <= 1'b0;
      com_rev    <= 1'b0;
      inverse    <= 1'b0;
      entire_on  <= 1'b0;
      disp_on    <= 1'b0;
    end else begin
      data_phase <= data_phase_next;
      pending    <= pending_next;
      arg_idx    <= arg_idx_next;
      col_start  <= col_start_next;
      col_end    <= col_end_next;
      pg_start   <= pg_start_next;
      pg_end     <= pg_end_next;
      col_ptr    <= col_ptr_next;
      pg_ptr     <= pg_ptr_next;
      contrast   <= contrast_next;
      start_line <= start_line_next;
      addr_mode  <= addr_mode_next;
      seg_remap  <= seg_remap_next;
      com_rev    <= com_rev_next;
      inverse    <= inverse_next;
      entire_on  <= entire_on_next;
      disp_on    <= disp_on_next;
    end
  end

  // Pixel write at the current pointer.
  always_comb begin
    wr.en     = bus_beat && !start_req && data_phase;
    wr.page   = pg_ptr;
    wr.column = col_ptr;
    wr.data   = byte_value;
  end

  // Status as seen after the latest beat.
  always_comb begin
    st.awaiting_argument = (arg_idx != 2'd0);
    st.scan_reverse      = com_rev;
    st.segment_flip      = seg_remap;
    st.first_line        = start_line;
    st.address_mode      = addr_mode;
    st.page_now          = pg_ptr;
    st.column_now        = col_ptr;
    st.all_pixels_on     = entire_on;
    st.inverse_video     = inverse;
    st.contrast_level    = contrast;
    st.display_enabled   = disp_on;
  end

  // The pointers never leave the store.
  a_col_in_store: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, col_ptr} < 8'(COLUMNS)))
    else $error("column pointer outside the store");

  a_page_in_store: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, pg_ptr} < 4'(PAGE_ROWS)))
    else $error("page pointer outside the store");

  // Two pending arguments only for the window commands.
  a_two_args: assert property (@(posedge clk) disable iff (rst)
    (arg_idx == 2'd2) |-> (pending == CMD_COL_WINDOW || pending == CMD_PAGE_WINDOW))
    else $error("two arguments pending for a one-argument command");

endmodule

`default_nettype wire

### rtl/oled_controller_command_ram_port_top.sv
// Top level of the OLED controller command and display-store port.
// Usage:
//   The slave stream carries one bus payload byte or one read request per beat.
//   s_tuser[0] selects a store read, s_tuser[1] marks the control byte that
//   opens a transaction. Each accepted beat yields exactly one master beat with
//   the read byte (zero for bus bytes) and the panel status after that beat.
// Pipeline:
//   The accepting edge registers the store read in the read stage; the output
//   register loads it when the read stage moves on. One beat is accepted every
//   cycle while s_tready is high; a read directly after a pixel write sees it.
// Reset:
//   After rst the display store is cleared one entry per cycle, COLUMNS *
//   PAGE_ROWS entries (1024 by default); s_tready stays low until it is done.
// Stall:
//   While m_tready is low the output register holds its beat, and one more
//   beat is taken into the read stage; then s_tready drops until the
//   receiver takes the waiting result.
`timescale 1ns / 1ps
`default_nettype none

module oled_controller_command_ram_port_top
  import ocrp_pkg::*;
#(
  parameter int COLUMNS   = COLUMNS_DEF,
  parameter int PAGE_ROWS = PAGE_ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // byte_value[7:0], read_page[10:8], read_column[17:11], zero fill [23:18]
  input  wire logic [23:0] s_tdata,
  // mode[0], start_req[1]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // read_data[7:0], display_enabled[8], contrast_level[16:9], inverse_video[17],
  // all_pixels_on[18], column_now[25:19], page_now[28:26], address_mode[30:29],
  // first_line[36:31], segment_flip[37], scan_reverse[38], awaiting_argument[39]
  output logic [39:0]      m_tdata
);

  logic              accept;
  logic              s1_adv;
  logic              s1_valid;
  logic              s1_rd;
  logic              rd_hit;
  logic [PAGE_W-1:0] rd_page;
  logic [COL_W-1:0]  rd_column;
  logic [7:0]        rd_data;
  logic              clearing;
  wr_t               wr;
  st_t               st;
  logic [7:0]        out_rd;
  st_t               out_st;

  assign rd_page   = s_tdata[10:8];
  assign rd_column = s_tdata[17:11];

  // Handshake: the read stage moves on when the output register is free.
  assign s1_adv   = !m_tvalid || m_tready;
  assign s_tready = !clearing && (!s1_valid || s1_adv);
  assign accept   = s_tvalid && s_tready;

  // Read request inside the store.
  assign rd_hit = s_tuser[0] && ({1'b0, rd_page} < 4'(PAGE_ROWS))
                  && ({1'b0, rd_column} < 8'(COLUMNS));

  ocrp_ctrl #(
    .COLUMNS   (COLUMNS),
    .PAGE_ROWS (PAGE_ROWS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .mode       (s_tuser[0]),
    .start_req  (s_tuser[1]),
    .byte_value (s_tdata[7:0]),
    .wr         (wr),
    .st         (st)
  );

  ocrp_store #(
    .COLUMNS   (COLUMNS),
    .PAGE_ROWS (PAGE_ROWS)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .rd_en     (accept && rd_hit),
    .rd_page   (rd_page),
    .rd_column (rd_column),
    .rd_data   (rd_data),
    .clearing  (clearing)
  );

  // Read stage: waits for the store's registered read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rd <= rd_hit;
    end
  end

  // Output register: read byte and the status after the staged beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      out_rd <= s1_rd ? rd_data : 8'h00;
      out_st <= st;
    end
  end

  assign m_tdata = {out_st, out_rd};

  // Every accepted beat reaches the read stage.
  a_accept_staged: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted beat missing from the read stage");

  // A blocked read stage keeps its beat.
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_rd)))
    else $error("read stage lost a blocked beat");

  // A staged beat that moves on becomes a visible result.
  a_stage_to_out: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_adv) |=> m_tvalid)
    else $error("staged beat did not reach the output");

endmodule

`default_nettype wire

### sim/oled_controller_command_ram_port_top_tb.sv
// Self-checking testbench for the OLED controller command and display-store port.
`timescale 1ns / 1ps

module oled_controller_command_ram_port_top_tb;
  import ocrp_pkg::*;

  localparam int NCOL  = COLUMNS_DEF;
  localparam int NPAGE = PAGE_ROWS_DEF;

  // Control byte values; bit 6 picks the data phase and bit 7 is don't-care.
  localparam logic [7:0] CTRL_CMD      = 8'h00;
  localparam logic [7:0] CTRL_DATA     = 8'h40;
  localparam int         CTRL_DATA_BIT = 6;

  localparam int DIR_ROWS     = 28;
  localparam int PHASE_BEATS  = 500;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 20;

  // One input beat, with an optional typed-in read byte.
  typedef struct packed {
    logic       mode;
    logic       start;
    logic [7:0] byte_v;
    logic [2:0] rp;
    logic [6:0] rc;
    logic       known;
    logic [7:0] known_rd;
  } beat_t;

  // Same layout as m_tdata: panel status above the read byte.
  typedef struct packed {
    st_t        st;
    logic [7:0] rd;
  } panel_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  oled_controller_command_ram_port_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  // Predicted panel state.
  logic [7:0] pix [0:NCOL*NPAGE-1];
  logic       data_ph = 1'b0;
  logic [7:0] pend_cmd = 8'h00;
  logic [1:0] args_left = 2'd0;
  logic [6:0] c_lo = 7'd0;
  logic [6:0] c_hi = 7'(NCOL - 1);
  logic [2:0] p_lo = 3'd0;
  logic [2:0] p_hi = 3'(NPAGE - 1);
  logic [6:0] col = 7'd0;
  logic [2:0] pg = 3'd0;
  logic [7:0] contrast = 8'h7F;
  logic [5:0] line = 6'd0;
  logic [1:0] amode = MODE_HORZ;
  logic       seg = 1'b0;
  logic       com = 1'b0;
  logic       inv = 1'b0;
  logic       ent = 1'b0;
  logic       disp_on = 1'b0;
  logic [6:0] lw_col = 7'd0;
  logic [2:0] lw_pg = 3'd0;

  panel_res_t status_q [$];
  int         errors = 0;
  int         beats_sent = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  bit         hold_req = 1'b0;
  bit         hold_started = 1'b0;
  int         hold_left = 0;

  beat_t dir_tab [DIR_ROWS];

  function automatic logic [6:0] sat_col(logic [7:0] v);
    int t;
    t = v & 8'h7F;
    return (t > NCOL - 1) ? 7'(NCOL - 1) : 7'(t);
  endfunction

  function automatic logic [2:0] sat_page(logic [7:0] v);
    int t;
    t = v & 8'h07;
    return (t > NPAGE - 1) ? 3'(NPAGE - 1) : 3'(t);
  endfunction

  // Column step inside the window; returns 1 when it wrapped to the start.
  function automatic bit advance_col();
    if (col == c_hi || col >= NCOL - 1) begin
      col = c_lo;
      return 1'b1;
    end
    col = col + 7'd1;
    return 1'b0;
  endfunction

  function automatic bit advance_page();
    if (pg == p_hi || pg >= NPAGE - 1) begin
      pg = p_lo;
      return 1'b1;
    end
    pg = pg + 3'd1;
    return 1'b0;
  endfunction

  // Applies one beat to the predicted panel and returns the status after it.
  function automatic panel_res_t panel_step(beat_t b);
    panel_res_t r;
    bit         first;
    logic [7:0] v;
    v = b.byte_v;
    r.rd = 8'h00;
    if (b.mode) begin
      if (b.rp < NPAGE && b.rc < NCOL) r.rd = pix[b.rp * NCOL + b.rc];
    end else if (b.start) begin
      data_ph = v[CTRL_DATA_BIT];
    end else if (data_ph) begin
      // Pixel byte: store it, then move the pointer for the current mode.
      pix[pg * NCOL + col] = v;
      lw_pg = pg;
      lw_col = col;
      if (amode == MODE_PAGE) begin
        void'(advance_col());
      end else if (amode == MODE_VERT) begin
        if (advance_page()) void'(advance_col());
      end else begin
        if (advance_col()) void'(advance_page());
      end
    end else if (args_left != 2'd0) begin
      // Argument byte of the pending command.
      first = (args_left == 2'd2);
      args_left = args_left - 2'd1;
      case (pend_cmd)
        CMD_ADDR_MODE: amode = v[1:0];
        CMD_COL_WINDOW: begin
          if (first) begin
            c_lo = sat_col(v);
            col = c_lo;
          end else begin
            c_hi = sat_col(v);
          end
        end
        CMD_PAGE_WINDOW: begin
          if (first) begin
            p_lo = sat_page(v);
            pg = p_lo;
          end else begin
            p_hi = sat_page(v);
          end
        end
        CMD_CONTRAST: contrast = v;
        // Mux, offset, pins, clock and pump settings are not visible at the outputs.
        default: ;
      endcase
    end else begin
      pend_cmd = v;
      case (v)
        CMD_ADDR_MODE, CMD_CONTRAST, CMD_MUX, CMD_OFFSET, CMD_PINS, CMD_CLOCK,
        CMD_PUMP: args_left = 2'd1;
        CMD_COL_WINDOW, CMD_PAGE_WINDOW: args_left = 2'd2;
        CMD_SEG_NORMAL: seg = 1'b0;
        CMD_SEG_FLIP: seg = 1'b1;
        CMD_FOLLOW_RAM: ent = 1'b0;
        CMD_ENTIRE_ON: ent = 1'b1;
        CMD_NORMAL: inv = 1'b0;
        CMD_INVERSE: inv = 1'b1;
        CMD_DISPLAY_OFF: disp_on = 1'b0;
        CMD_DISPLAY_ON: disp_on = 1'b1;
        default: begin
          if (v >= CMD_START_LINE_LO && v <= CMD_START_LINE_HI) begin
            line = v[5:0];
          end else if (v >= CMD_COM_SCAN_LO && v <= CMD_COM_SCAN_HI) begin
            com = v[3];
          end else if (amode == MODE_PAGE) begin
            // Pointer nudges only act in page mode.
            if (v <= CMD_COL_LOW_HI)
              col = sat_col({1'b0, col[6:4], v[3:0]});
            else if (v <= CMD_COL_HIGH_HI)
              col = sat_col({1'b0, v[2:0], col[3:0]});
            else if (v >= CMD_PAGE_SEL_LO && v <= CMD_PAGE_SEL_HI)
              pg = sat_page(v);
          end
        end
      endcase
    end
    r.st.display_enabled   = disp_on;
    r.st.contrast_level    = contrast;
    r.st.inverse_video     = inv;
    r.st.all_pixels_on     = ent;
    r.st.column_now        = col;
    r.st.page_now          = pg;
    r.st.address_mode      = amode;
    r.st.first_line        = line;
    r.st.segment_flip      = seg;
    r.st.scan_reverse      = com;
    r.st.awaiting_argument = (args_left != 2'd0);
    return r;
  endfunction

  // Bus payload beat with random read address bits riding along.
  function automatic beat_t bus_beat(logic start, logic [7:0] v);
    beat_t b;
    b.mode = 1'b0;
    b.start = start;
    b.byte_v = v;
    b.rp = 3'($urandom_range(7));
    b.rc = 7'($urandom_range(127));
    b.known = 1'b0;
    b.known_rd = 8'h00;
    return b;
  endfunction

  // Offers one beat, entered and left at a falling edge.
  task automatic offer_beat(beat_t b);
    panel_res_t exp;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, b.rc, b.rp, b.byte_v};
    s_tuser <= {b.start, b.mode};
    do @(posedge clk); while (!s_tready);
    exp = panel_step(b);
    if (b.known) exp.rd = b.known_rd;
    status_q.push_back(exp);
    beats_sent++;
    @(negedge clk);
  endtask

  // Sends the arguments of a command; now and then the run is cut short.
  task automatic offer_args(logic [7:0] c);
    int         n;
    logic [7:0] v;
    n = (c == CMD_COL_WINDOW || c == CMD_PAGE_WINDOW) ? 2 : 1;
    for (int a = 0; a < n; a++) begin
      if ($urandom_range(19) == 0) break;
      v = 8'($urandom_range(255));
      if (c == CMD_COL_WINDOW && $urandom_range(3) != 0) v = 8'($urandom_range(127));
      if (c == CMD_PAGE_WINDOW && $urandom_range(3) != 0) v = 8'($urandom_range(7));
      offer_beat(bus_beat(1'b0, v));
    end
  endtask

  // Returns to idle and waits until every expected result has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (a !== e) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
      errors++;
    end
  endtask

  // Result checker: every accepted output beat against the oldest prediction.
  always @(posedge clk) begin
    panel_res_t exp;
    panel_res_t act;
    if (!rst && m_tvalid && m_tready) begin
      act = panel_res_t'(m_tdata);
      if (status_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, m_tdata);
        errors++;
      end else begin
        exp = status_q.pop_front();
        check_field("read_data", exp.rd, act.rd);
        check_field("display_enabled", exp.st.display_enabled, act.st.display_enabled);
        check_field("contrast_level", exp.st.contrast_level, act.st.contrast_level);
        check_field("inverse_video", exp.st.inverse_video, act.st.inverse_video);
        check_field("all_pixels_on", exp.st.all_pixels_on, act.st.all_pixels_on);
        check_field("column_now", exp.st.column_now, act.st.column_now);
        check_field("page_now", exp.st.page_now, act.st.page_now);
        check_field("address_mode", exp.st.address_mode, act.st.address_mode);
        check_field("first_line", exp.st.first_line, act.st.first_line);
        check_field("segment_flip", exp.st.segment_flip, act.st.segment_flip);
        check_field("scan_reverse", exp.st.scan_reverse, act.st.scan_reverse);
        check_field("awaiting_argument", exp.st.awaiting_argument,
                    act.st.awaiting_argument);
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off when asked.
  always @(negedge clk) begin
    if (hold_req && !hold_started) begin
      hold_started = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Run limit.
  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  // Stimulus.
  initial begin
    int         kind;
    int         n;
    logic [7:0] c;
    beat_t      b;
    logic [7:0] arg_cmds [9];
    logic [7:0] one_byte [8];

    arg_cmds = '{CMD_ADDR_MODE, CMD_COL_WINDOW, CMD_PAGE_WINDOW, CMD_CONTRAST, CMD_MUX,
                 CMD_OFFSET, CMD_PINS, CMD_CLOCK, CMD_PUMP};
    one_byte = '{CMD_SEG_NORMAL, CMD_SEG_FLIP, CMD_FOLLOW_RAM, CMD_ENTIRE_ON, CMD_NORMAL,
                 CMD_INVERSE, CMD_DISPLAY_OFF, CMD_DISPLAY_ON};
    for (int i = 0; i < NCOL * NPAGE; i++) pix[i] = 8'h00;

    // Fields: mode, start, byte, read page, read column, typed-in flag, read byte.
    dir_tab = '{
      // Cleared store at both corners; a read ignores the start flag.
      '{1'b1, 1'b0, 8'h00, 3'd0, 7'd0, 1'b1, 8'h00},
      '{1'b1, 1'b1, 8'hFF, 3'd7, 7'd127, 1'b1, 8'h00},
      '{1'b0, 1'b1, CTRL_CMD, 3'd0, 7'd0, 1'b0, 8'h00},
      '{1'b0, 1'b0, CMD_DISPLAY_ON, 3'd0, 7'd0, 1'b0, 8'h00},
      '{1'b0, 1'b0, CMD_CONTRAST, 3'd0, 7'd0, 1'b0, 8'h00},
      '{1'b0, 1'b0, 8'hFF, 3'd0, 7'd0, 1'b0, 8'h00},
      '{1'b0, 1'b0, CMD_SEG_FLIP, 3'd0, 7'd0, 1'b0, 8'h00},
      '{1'b0, 1'b0, CMD_ENTIRE_ON, 3'd0, 7'd0, 1'b0, 8'h00},
      '{1'b0, 1'b0, CMD_INVERSE, 3'd0, 7'd0, 1'b0, 8'h00},
      '{1'b0, 1'b0, CMD_START_LINE_HI, 3'd0, 7'd0, 1'b0, 8'h00},
      '{1'b0, 1'b0, CMD_COM_SCAN_LO | 8'h08, 3'd0, 7'd0, 1'b0, 8'h00},
      // Column window start at the last column, then the end arrives after a new control byte.
      '{1'b0, 1'b0, CMD_COL_WINDOW, 3'd0, 7'd0, 1'b0, 8'h00},
      '{1'b0, 1'b0, 8'hFF, 3'd0, 7'd0, 1'b0, 8'h00},
      '{1'b0, 1'b1, CTRL_CMD | 8'h80, 3'd0, 7'd0, 1'b0, 8'h00},
      '{1'b0, 1'b0, 8'h05, 3'd0, 7'd0, 1'b0, 8'h00},
      // Start above end: a write at the last column wraps to the window start.
      '{1'b0, 1'b1, CTRL_DATA | 8'h80, 3'd0, 7'd0, 1'b0, 8'h00},
      '{1'b0, 1'b0, 8'hFF, 3'd5, 7'd85, 1'b0, 8'h00},
      '{1'b1, 1'b0, 8'h00, 3'd0, 7'd127, 1'b1, 8'hFF},
      // Pixel data while an argument is still pending.
      '{1'b0, 1'b1, CTRL_CMD, 3'd0, 7'd0, 1'b0, 8'h00},
      '{1'b0, 1'b0, CMD_ADDR_MODE, 3'd0, 7'd0, 1'b0, 8'h00},
      '{1'b0, 1'b1, CTRL_DATA, 3'd0, 7'd0, 1'b0, 8'h00},
      '{1'b0, 1'b0, 8'h5A, 3'd2, 7'd42, 1'b0, 8'h00},
      '{1'b0, 1'b1, CTRL_CMD | 8'h3F, 3'd0, 7'd0, 1'b0, 8'h00},
      '{1'b0, 1'b0, {6'd0, MODE_PAGE}, 3'd0, 7'd0, 1'b0, 8'h00},
      // Page-mode pointer commands and an unknown opcode.
      '{1'b0, 1'b0, CMD_COL_HIGH_HI, 3'd0, 7'd0, 1'b0, 8'h00},
      '{1'b0, 1'b0, CMD_COL_LOW_HI, 3'd0, 7'd0, 1'b0, 8'h00},
      '{1'b0, 1'b0, CMD_PAGE_SEL_HI, 3'd0, 7'd0, 1'b0, 8'h00},
      '{1'b0, 1'b0, 8'hE3, 3'd0, 7'd0, 1'b0, 8'h00}
    };

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 23; recv_idle_pct = 52; end
        1: begin send_idle_pct = 52; recv_idle_pct = 23; end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req = 1'b1;
        end
      endcase
      if (ph == 0) begin
        for (int i = 0; i < DIR_ROWS; i++) offer_beat(dir_tab[i]);
      end

      while (beats_sent < (ph + 1) * PHASE_BEATS) begin
        kind = $urandom_range(99);
        if (kind < 45) begin
          // Command transaction.
          offer_beat(bus_beat(1'b1, {1'($urandom_range(1)), 1'b0, 6'($urandom_range(63))}));
          n = $urandom_range(1, 6);
          repeat (n) begin
            case ($urandom_range(15))
              0, 1, 2, 3, 4: begin
                c = arg_cmds[$urandom_range(8)];
                offer_beat(bus_beat(1'b0, c));
                offer_args(c);
              end
              5, 6, 7: offer_beat(bus_beat(1'b0, one_byte[$urandom_range(7)]));
              8: offer_beat(bus_beat(1'b0, CMD_START_LINE_LO | 8'($urandom_range(63))));
              9: offer_beat(bus_beat(1'b0, CMD_COM_SCAN_LO | 8'($urandom_range(15))));
              10, 11: offer_beat(bus_beat(1'b0, 8'($urandom_range(31))));
              12: offer_beat(bus_beat(1'b0, CMD_PAGE_SEL_LO | 8'($urandom_range(7))));
              13: offer_beat(bus_beat(1'b0, 8'($urandom_range(255))));
              default: begin
                // Go to page mode with random upper bits in the argument.
                offer_beat(bus_beat(1'b0, CMD_ADDR_MODE));
                offer_beat(bus_beat(1'b0, {6'($urandom_range(63)), MODE_PAGE}));
              end
            endcase
          end
        end else if (kind < 85) begin
          // Pixel transaction, now and then reading back the last written byte.
          offer_beat(bus_beat(1'b1, {1'($urandom_range(1)), 1'b1, 6'($urandom_range(63))}));
          n = $urandom_range(1, 16);
          repeat (n) begin
            if ($urandom_range(99) < 15) begin
              b = bus_beat(1'($urandom_range(1)), 8'($urandom_range(255)));
              b.mode = 1'b1;
              b.rp = lw_pg;
              b.rc = lw_col;
              offer_beat(b);
            end else begin
              offer_beat(bus_beat(1'b0, 8'($urandom_range(255))));
            end
          end
        end else if (kind < 95) begin
          // Random store reads.
          n = $urandom_range(1, 4);
          repeat (n) begin
            b = bus_beat(1'($urandom_range(1)), 8'($urandom_range(255)));
            b.mode = 1'b1;
            offer_beat(b);
          end
        end else begin
          // Noise beat with every field random.
          b = bus_beat(1'($urandom_range(1)), 8'($urandom_range(255)));
          b.mode = 1'($urandom_range(1));
          offer_beat(b);
        end
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### oled_controller_command_ram_port_top.f
rtl/ocrp_pkg.sv
rtl/ocrp_store.sv
rtl/ocrp_ctrl.sv
rtl/oled_controller_command_ram_port_top.sv
sim/oled_controller_command_ram_port_top_tb.sv
